/* sv/bffa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit allocator package
// Shared sizes, status codes, sequencer states and the extent write bundle.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam logic [7:0] HEAP_BYTES   = 8'd128;
    localparam logic [7:0] HEADER_BYTES = 8'd4;
    localparam int LIST_ENTRIES = 64;
    localparam int LIST_IDX_W   = $clog2(LIST_ENTRIES);
    localparam int COUNT_W      = $clog2(LIST_ENTRIES + 1);
    localparam int REC_DEPTH    = 128;
    localparam int REC_IDX_W    = $clog2(REC_DEPTH);

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_FIT    = 2'd2,
        ST_LIST_FULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_FREE_WB
    } t_state;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

    typedef struct packed {
        logic                  en;
        logic [LIST_IDX_W-1:0] idx;
        logic [7:0]            start;
        logic [7:0]            bytes;
    } t_ext_wr;

endpackage

/* sv/bffa_extent_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent list store
// Start and size memories of the free extents, one write and one registered
// read per cycle. Entry 0 reads as the whole heap until it is first written.
// ----------------------------------------------------------------------------
module bffa_extent_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bffa_pkg::LIST_IDX_W-1:0] i_rd_idx,
    input  bffa_pkg::t_ext_wr          i_wr,
    output logic [7:0]                 o_rd_start,
    output logic [7:0]                 o_rd_bytes
);
    import bffa_pkg::*;

    logic [7:0] r_start_mem [LIST_ENTRIES];
    logic [7:0] r_bytes_mem [LIST_ENTRIES];
    logic [7:0] r_rd_start;
    logic [7:0] r_rd_bytes;
    logic       r_rd_is0;
    logic       r_e0_written;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_start_mem[i_wr.idx] <= i_wr.start;
            r_bytes_mem[i_wr.idx] <= i_wr.bytes;
        end
        r_rd_start <= r_start_mem[i_rd_idx];
        r_rd_bytes <= r_bytes_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_written <= 1'b0;
            r_rd_is0     <= 1'b0;
        end else begin
            r_rd_is0 <= (i_rd_idx == '0);
            if (i_wr.en && i_wr.idx == '0) begin
                r_e0_written <= 1'b1;
            end
        end
    end

    // entry 0 holds the whole heap until an allocation rewrites it
    assign o_rd_start = (r_rd_is0 && !r_e0_written) ? 8'd0 : r_rd_start;
    assign o_rd_bytes = (r_rd_is0 && !r_e0_written) ? HEAP_BYTES : r_rd_bytes;

endmodule

/* sv/best_fit_free_list_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit free-list allocator
// Small heap manager: best-fit allocate from a list of free extents, and
// free by appending the released block as a new extent.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate scans the extent list with a
// single compare unit. The extent memory read is registered, and the scan
// handles one entry per cycle. A successful allocate registers its result
// in the commit state that follows the scan. When no extent fits, the scan
// state registers the result as the scan ends. A free registers the size
// lookup at the transfer, and the append in the free write-back state
// registers the result. A rejected request shows its result at the transfer
// edge itself. The input side is ready again in the cycle after the result
// transfer. A request above the heap size, no extent large enough, or a free
// with a full list gives an error status with zero address and size and
// leaves the heap unchanged.
// ----------------------------------------------------------------------------
module best_fit_free_list_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [7:0] request_bytes, [15:8] free_address
    input  logic [bffa_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [0] mode
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [1:0] status, [9:2] user_address, [17:10] block_bytes, [23:18] zero
    output logic [bffa_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import bffa_pkg::*;

    t_state                 r_state, n_state;
    logic [COUNT_W-1:0]     r_count, n_count;
    logic [COUNT_W-1:0]     r_idx, n_idx;
    logic                   r_rd_valid, n_rd_valid;
    logic [LIST_IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic [7:0]             r_total, n_total;
    logic                   r_found, n_found;
    logic [LIST_IDX_W-1:0]  r_best_idx, n_best_idx;
    logic [7:0]             r_best_start, n_best_start;
    logic [7:0]             r_best_bytes, n_best_bytes;
    logic [7:0]             r_fstart, n_fstart;

    logic                   r_out_valid, n_out_valid;
    t_status                r_out_status, n_out_status;
    logic [7:0]             r_out_addr, n_out_addr;
    logic [7:0]             r_out_bytes, n_out_bytes;

    logic [7:0]             r_rec_mem [REC_DEPTH];
    logic [7:0]             r_rec_rd;
    logic                   rec_we;
    logic [REC_IDX_W-1:0]   rec_waddr;
    logic [REC_IDX_W-1:0]   rec_raddr;

    t_ext_wr                ext_wr;
    logic [LIST_IDX_W-1:0]  ext_rd_idx;
    logic [7:0]             ext_rd_start;
    logic [7:0]             ext_rd_bytes;

    logic                   in_xfer;
    logic                   out_xfer;
    logic [7:0]             in_req;
    logic [7:0]             in_faddr;
    logic [8:0]             req_sum;
    logic [7:0]             free_start;
    logic                   scan_done;
    logic                   cand_hit;

    assign in_req     = i_s_axis_tdata[7:0];
    assign in_faddr   = i_s_axis_tdata[15:8];
    assign req_sum    = {1'b0, in_req} + {1'b0, HEADER_BYTES};
    assign free_start = in_faddr - HEADER_BYTES;

    assign o_s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = r_out_valid && i_m_axis_tready;

    assign scan_done = (r_idx >= r_count) && !r_rd_valid;
    assign cand_hit  = r_rd_valid && (ext_rd_bytes >= r_total)
                       && (!r_found || ext_rd_bytes < r_best_bytes);

    bffa_extent_store u_ext (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (ext_rd_idx),
        .i_wr       (ext_wr),
        .o_rd_start (ext_rd_start),
        .o_rd_bytes (ext_rd_bytes)
    );

    // recorded block sizes, indexed by block start offset
    assign rec_raddr = free_start[REC_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_rec_mem[rec_waddr] <= r_total;
        end
        r_rec_rd <= r_rec_mem[rec_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (t_mode'(i_s_axis_tuser) == MODE_ALLOC) begin
                        if (in_req <= HEAP_BYTES) begin
                            n_state = S_SCAN;
                        end
                    end else if (r_count < COUNT_W'(LIST_ENTRIES)) begin
                        n_state = S_FREE_WB;
                    end
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = r_found ? S_COMMIT : S_IDLE;
                end
            end
            S_COMMIT:  n_state = S_IDLE;
            S_FREE_WB: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_rd_valid   = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_total      = r_total;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_start = r_best_start;
        n_best_bytes = r_best_bytes;
        n_fstart     = r_fstart;
        n_out_valid  = out_xfer ? 1'b0 : r_out_valid;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        n_out_bytes  = r_out_bytes;
        ext_rd_idx   = r_idx[LIST_IDX_W-1:0];
        ext_wr       = '0;
        rec_we       = 1'b0;
        rec_waddr    = r_best_start[REC_IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_total  = req_sum[7:0];
                    n_fstart = free_start;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    if (t_mode'(i_s_axis_tuser) == MODE_ALLOC) begin
                        if (in_req > HEAP_BYTES) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_TOO_LARGE;
                            n_out_addr   = '0;
                            n_out_bytes  = '0;
                        end
                    end else if (r_count >= COUNT_W'(LIST_ENTRIES)) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_LIST_FULL;
                        n_out_addr   = '0;
                        n_out_bytes  = '0;
                    end
                end
            end
            S_SCAN: begin
                // compare the entry read last cycle; strict less keeps the lowest on a tie
                if (cand_hit) begin
                    n_found      = 1'b1;
                    n_best_idx   = r_rd_idx;
                    n_best_start = ext_rd_start;
                    n_best_bytes = ext_rd_bytes;
                end
                // issue the next read
                if (r_idx < r_count) begin
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_idx[LIST_IDX_W-1:0];
                    n_idx      = r_idx + COUNT_W'(1);
                end
                if (scan_done && !r_found) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_NO_FIT;
                    n_out_addr   = '0;
                    n_out_bytes  = '0;
                end
            end
            S_COMMIT: begin
                // carve the block from the front of the best extent
                ext_wr.en    = 1'b1;
                ext_wr.idx   = r_best_idx;
                ext_wr.start = r_best_start + r_total;
                ext_wr.bytes = r_best_bytes - r_total;
                rec_we       = 1'b1;
                n_out_valid  = 1'b1;
                n_out_status = ST_OK;
                n_out_addr   = r_best_start + HEADER_BYTES;
                n_out_bytes  = r_total;
            end
            S_FREE_WB: begin
                // append the released block as a new extent
                ext_wr.en    = 1'b1;
                ext_wr.idx   = r_count[LIST_IDX_W-1:0];
                ext_wr.start = r_fstart;
                ext_wr.bytes = r_rec_rd;
                n_count      = r_count + COUNT_W'(1);
                n_out_valid  = 1'b1;
                n_out_status = ST_OK;
                n_out_addr   = '0;
                n_out_bytes  = r_rec_rd;
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= COUNT_W'(1);
            r_rd_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_valid  <= n_rd_valid;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_rd_idx     <= n_rd_idx;
        r_total      <= n_total;
        r_best_idx   <= n_best_idx;
        r_best_start <= n_best_start;
        r_best_bytes <= n_best_bytes;
        r_fstart     <= n_fstart;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
        r_out_bytes  <= n_out_bytes;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_bytes, r_out_addr, r_out_status};

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= COUNT_W'(1)) && (r_count <= COUNT_W'(LIST_ENTRIES)))
        else $error("extent count out of range");

    a_free_appends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE_WB) |=> (r_count == $past(r_count) + COUNT_W'(1)))
        else $error("free did not append an extent");

    a_commit_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> (r_found && r_best_bytes >= r_total))
        else $error("committed extent too small");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_addr == '0 && r_out_bytes == '0))
        else $error("error result carries nonzero fields");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !scan_done) |=> !$rose(r_out_valid))
        else $error("result raised while scan still running");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit free-list allocator testbench
// Drives allocate and free requests into the allocator stream port and checks
// every result against a behavioral heap model in the bench, or typed requests
// against their fixed result. A short table of directed requests comes first, then
// constrained-random traffic with random idling on both sides, a long output
// back-pressure window, a drain pause, and a closing pass that fills the extent list.
// ----------------------------------------------------------------------------
module tb;
    import bffa_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_ITEMS  = 400;
    localparam int DRAIN_CYCLES  = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT_NS    = 4_800_000;
    localparam int MAX_PRINTED   = 100;
    localparam int NUM_DIRECTED  = 18;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] req;
        logic [7:0] addr;
    } heap_req_t;

    typedef struct packed {
        t_status    status;
        logic [7:0] user_addr;
        logic [7:0] block_bytes;
    } heap_rsp_t;

    typedef struct packed {
        heap_req_t  req;
        logic       typed;
        heap_rsp_t  want;
    } directed_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;   // [7:0] request_bytes, [15:8] free_address
    logic                  i_s_axis_tuser;   // [0] mode
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;   // [1:0] status, [9:2] user_address,
                                             // [17:10] block_bytes, [23:18] zero

    best_fit_free_list_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Heap model state
    logic [7:0] ext_start [LIST_ENTRIES];
    logic [7:0] ext_bytes [LIST_ENTRIES];
    int         ext_count;
    logic [7:0] block_size_at [REC_DEPTH];
    bit         size_written [REC_DEPTH];

    heap_rsp_t  predicted_results [$];
    logic [7:0] live_addrs [$];
    bit         sender_quiet;
    int         mismatch_count;
    int         results_seen;
    int         status_seen [4];
    int         directed_sent;
    int         random_sent;
    int         fill_sent;

    // After reset: one extent covering the whole heap.
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{'{MODE_ALLOC, 8'd129, 8'd0},   1'b1, '{ST_TOO_LARGE, 8'd0, 8'd0}},
        '{'{MODE_ALLOC, 8'd255, 8'd128}, 1'b1, '{ST_TOO_LARGE, 8'd0, 8'd0}},
        '{'{MODE_ALLOC, 8'd128, 8'd0},   1'b1, '{ST_NO_FIT,    8'd0, 8'd0}},
        '{'{MODE_ALLOC, 8'd124, 8'd0},   1'b1, '{ST_OK,        8'd4, 8'd128}},
        '{'{MODE_ALLOC, 8'd0,   8'd0},   1'b1, '{ST_NO_FIT,    8'd0, 8'd0}},
        '{'{MODE_FREE,  8'd255, 8'd4},   1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{'{MODE_ALLOC, 8'd0,   8'd0},   1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{'{MODE_ALLOC, 8'd120, 8'd0},   1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{'{MODE_FREE,  8'd0,   8'd8},   1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{'{MODE_FREE,  8'd17,  8'd4},   1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{'{MODE_ALLOC, 8'd0,   8'd0},   1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{'{MODE_ALLOC, 8'd116, 8'd0},   1'b0, '{ST_OK, 8'd0, 8'd0}},
        // carve the last four bytes: user address lands on the heap end
        '{'{MODE_ALLOC, 8'd0,   8'd0},   1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{'{MODE_FREE,  8'd0,   8'd128}, 1'b0, '{ST_OK, 8'd0, 8'd0}},
        // never returned by an allocate; offset wraps below zero
        '{'{MODE_FREE,  8'd0,   8'd0},   1'b0, '{ST_OK, 8'd0, 8'd0}},
        // two equal extents: lowest entry wins
        '{'{MODE_ALLOC, 8'd0,   8'd0},   1'b0, '{ST_OK, 8'd0, 8'd0}},
        // wrapped extent: user address wraps to zero
        '{'{MODE_ALLOC, 8'd0,   8'd0},   1'b0, '{ST_OK, 8'd0, 8'd0}},
        '{'{MODE_FREE,  8'd99,  8'd0},   1'b0, '{ST_OK, 8'd0, 8'd0}}
    };

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic heap_rsp_t predict_heap_op(heap_req_t rq);
        heap_rsp_t  r;
        logic [7:0] total;
        logic [7:0] start;
        int         best;
        bit         found;
        int         i;
        r = '{ST_OK, 8'd0, 8'd0};
        if (rq.mode == MODE_ALLOC) begin
            if (rq.req > HEAP_BYTES) begin
                r.status = ST_TOO_LARGE;
            end else begin
                total = rq.req + HEADER_BYTES;
                found = 1'b0;
                best  = 0;
                for (i = 0; i < ext_count; i++) begin
                    if (ext_bytes[i] >= total && (!found || ext_bytes[i] < ext_bytes[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = ST_NO_FIT;
                end else begin
                    start = ext_start[best];
                    block_size_at[start[REC_IDX_W-1:0]] = total;
                    size_written[start[REC_IDX_W-1:0]]  = 1'b1;
                    ext_start[best] = start + total;
                    ext_bytes[best] = ext_bytes[best] - total;
                    r.user_addr   = start + HEADER_BYTES;
                    r.block_bytes = total;
                end
            end
        end else begin
            if (ext_count >= LIST_ENTRIES) begin
                r.status = ST_LIST_FULL;
            end else begin
                start = rq.addr - HEADER_BYTES;
                ext_start[ext_count] = start;
                ext_bytes[ext_count] = block_size_at[start[REC_IDX_W-1:0]];
                r.block_bytes = block_size_at[start[REC_IDX_W-1:0]];
                ext_count++;
            end
        end
        return r;
    endfunction

    // Only offsets written by an allocate may be freed.
    function automatic logic [7:0] pick_free_addr(bit any_written);
        logic [7:0] a;
        logic [7:0] off;
        int         tries;
        if (!any_written && live_addrs.size() > 0) begin
            return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        end
        for (tries = 0; tries < 16; tries++) begin
            a   = 8'($urandom_range(0, 128));
            off = a - HEADER_BYTES;
            if (size_written[off[REC_IDX_W-1:0]]) begin
                return a;
            end
        end
        return 8'd4;
    endfunction

    function automatic heap_req_t random_request();
        heap_req_t rq;
        int        pick;
        rq.req  = 8'($urandom_range(0, 255));
        rq.addr = 8'($urandom_range(0, 128));
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            rq.mode = MODE_FREE;
            rq.addr = pick_free_addr(1'b0);
        end else if (pick < 17) begin
            rq.mode = MODE_FREE;
            rq.addr = pick_free_addr(1'b1);
        end else begin
            rq.mode = MODE_ALLOC;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                rq.req = 8'($urandom_range(0, 12));
            end else if (pick < 85) begin
                rq.req = 8'($urandom_range(13, 60));
            end else if (pick < 90) begin
                rq.req = 8'($urandom_range(61, 128));
            end else if (pick < 96) begin
                rq.req = 8'($urandom_range(129, 255));
            end else begin
                rq.req = pick[0] ? HEAP_BYTES : 8'd0;
            end
        end
        return rq;
    endfunction

    // Call in the time step of a rising edge; returns in the step of the transfer.
    task automatic send_request(heap_req_t rq, logic typed, heap_rsp_t want);
        heap_rsp_t pred;
        int        k;
        int        idle_pct;
        idle_pct = sender_quiet ? 0 : 35;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {rq.addr, rq.req};
        i_s_axis_tuser  <= rq.mode;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        pred = predict_heap_op(rq);
        predicted_results.push_back(typed ? want : pred);
        if (pred.status == ST_OK) begin
            if (rq.mode == MODE_ALLOC) begin
                live_addrs.push_back(pred.user_addr);
            end else begin
                for (k = 0; k < live_addrs.size(); k++) begin
                    if (live_addrs[k] == rq.addr) begin
                        live_addrs.delete(k);
                        break;
                    end
                end
            end
        end
    endtask

    task automatic report_mismatch(string what, int seq, logic [7:0] got, logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("[%0t] result %0d: %s got 0x%02h expected 0x%02h", $realtime, seq, what,
                     got, want);
        end
    endtask

    initial begin : drive_requests
        int        n;
        heap_req_t rq;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        sender_quiet    = 1'b0;
        mismatch_count  = 0;
        directed_sent   = 0;
        random_sent     = 0;
        fill_sent       = 0;
        for (n = 0; n < LIST_ENTRIES; n++) begin
            ext_start[n] = 8'd0;
            ext_bytes[n] = 8'd0;
        end
        for (n = 0; n < REC_DEPTH; n++) begin
            block_size_at[n] = 8'd0;
            size_written[n]  = 1'b0;
        end
        ext_bytes[0] = HEAP_BYTES;
        ext_count    = 1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < NUM_DIRECTED; n++) begin
            send_request(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);
            directed_sent++;
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            sender_quiet = (n >= 200 && n < 280);
            if (n == 300) begin
                // hold off until every outstanding result is back
                i_s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (predicted_results.size() != 0);
            end
            send_request(random_request(), 1'b0, '0);
            random_sent++;
        end
        sender_quiet = 1'b0;

        // fill the extent list, then one free past the end of it
        while (ext_count < LIST_ENTRIES) begin
            rq = '{MODE_FREE, 8'($urandom_range(0, 255)), pick_free_addr(1'b0)};
            send_request(rq, 1'b0, '0);
            fill_sent++;
        end
        rq = '{MODE_FREE, 8'($urandom_range(0, 255)), pick_free_addr(1'b0)};
        send_request(rq, 1'b1, '{ST_LIST_FULL, 8'd0, 8'd0});
        fill_sent++;

        i_s_axis_tvalid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d directed, %0d random and %0d list-fill requests; %0d results checked",
                 directed_sent, random_sent, fill_sent, results_seen);
        $display("Status mix: ok %0d, too large %0d, no fit %0d, list full %0d",
                 status_seen[ST_OK], status_seen[ST_TOO_LARGE], status_seen[ST_NO_FIT],
                 status_seen[ST_LIST_FULL]);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : collect_results
        int        hold_left;
        bit        hold_done;
        bit        ready_next;
        heap_rsp_t got;
        heap_rsp_t want;
        hold_left       = 0;
        hold_done       = 1'b0;
        results_seen    = 0;
        status_seen     = '{0, 0, 0, 0};
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
                got.status      = t_status'(o_m_axis_tdata[1:0]);
                got.user_addr   = o_m_axis_tdata[9:2];
                got.block_bytes = o_m_axis_tdata[17:10];
                if (predicted_results.size() == 0) begin
                    report_mismatch("unexpected transfer, status", results_seen,
                                    8'(got.status), 8'd0);
                end else begin
                    want = predicted_results.pop_front();
                    status_seen[want.status]++;
                    if (got.status !== want.status)
                        report_mismatch("status", results_seen, 8'(got.status),
                                        8'(want.status));
                    if (got.user_addr !== want.user_addr)
                        report_mismatch("user_address", results_seen, got.user_addr,
                                        want.user_addr);
                    if (got.block_bytes !== want.block_bytes)
                        report_mismatch("block_bytes", results_seen, got.block_bytes,
                                        want.block_bytes);
                    if (o_m_axis_tdata[23:18] !== 6'd0)
                        report_mismatch("pad bits", results_seen,
                                        8'(o_m_axis_tdata[23:18]), 8'd0);
                end
                results_seen++;
                if (results_seen == 120 && !hold_done) begin
                    // back-pressure long enough for the input side to stall
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (results_seen >= 200 && results_seen < 280) begin
                ready_next = 1'b1;
            end else begin
                ready_next = ($urandom_range(0, 99) >= 35);
            end
            i_m_axis_tready <= ready_next;
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", predicted_results.size());
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/bffa_pkg.sv
sv/bffa_extent_store.sv
sv/best_fit_free_list_allocator.sv
tb/tb.sv
